// ===== rtl/c_comment_stripper_top_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros of the comment stripper RTL.
// ---------------------------------------------------------------------------
`ifndef C_COMMENT_STRIPPER_TOP_DEFINES_SVH
`define C_COMMENT_STRIPPER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define CCS_ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
		else $error("comment stripper: forbidden condition seen");

`define CCS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("comment stripper: implication failed");

`define CCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("comment stripper: next-cycle check failed");

`else

`define CCS_ASSERT_NEVER(label, clk, rst_n, expr)
`define CCS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define CCS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/ccs_pkg.sv =====
// ---------------------------------------------------------------------------
// ccs_pkg
// Shared types and constants of the C comment stripper.
// ---------------------------------------------------------------------------
`default_nettype none

package ccs_pkg;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_NL    = 8'h0A;

	localparam int QUEUE_DEPTH_DEF = 4;

	// Scanner mode, one-hot.
	typedef enum logic [4:0] {
		MODE_NORMAL = 5'b00001,
		MODE_SLASH  = 5'b00010,
		MODE_LINE   = 5'b00100,
		MODE_BLOCK  = 5'b01000,
		MODE_STAR   = 5'b10000
	} mode_t;

	// One queued output command: a kept byte, optionally preceded by a
	// held slash that turned out not to open a comment.
	typedef struct packed {
		logic       pair;
		logic [7:0] data;
	} cmd_t;

endpackage

`default_nettype wire

// ===== rtl/c_comment_stripper_top.sv =====
// Comment stripper: removes // and /* */ comments from a byte stream.
// Input channel s_*: one text byte per transaction in s_tdata, s_tlast marks
// the final byte of a text. Output channel m_*: kept bytes in m_tdata, with
// m_tlast set on the last output caused by one input byte.
// Each input byte produces zero, one or two outputs; two when a held slash
// proves not to open a comment (the slash, then the byte itself).
// A scanner stage classifies each byte in the cycle it is accepted and writes
// a command to a short queue (QUEUE_DEPTH entries); an output stage reads the
// queue head and drives m_* directly from it.
// Throughput: one input byte per cycle while the queue has room; the output
// stage sends one byte per cycle while m_tready is high, so a slash pair
// takes two output transactions. When m_tready is held low the queue fills
// and s_tready then drops; no data is lost. Reset empties the queue and
// returns the scanner to normal text.
// ---------------------------------------------------------------------------
// c_comment_stripper_top
// Top level of the C comment stripper.
// ---------------------------------------------------------------------------
`default_nettype none
`include "c_comment_stripper_top_defines.svh"

module c_comment_stripper_top
	import ccs_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] text_byte
	input  wire logic       s_tlast,   // end_of_text
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] kept_byte
	output logic            m_tlast    // run_last
);

	logic queue_full;
	logic queue_not_empty;
	logic push;
	logic pop;
	cmd_t push_cmd;
	cmd_t head_cmd;

	ccs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_byte   (s_tdata),
		.in_last   (s_tlast),
		.queue_full(queue_full),
		.in_ready  (s_tready),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	ccs_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.full     (queue_full),
		.not_empty(queue_not_empty),
		.head     (head_cmd)
	);

	ccs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(queue_not_empty),
		.cmd      (head_cmd),
		.pop      (pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_byte (m_tdata),
		.out_last (m_tlast)
	);

	// A full queue always has a head to present.
	`CCS_ASSERT_IMPLIES(a_full_has_output, clk, arst_n, !s_tready, m_tvalid)

	// Only a held slash goes out without the last flag.
	`CCS_ASSERT_IMPLIES(a_nonlast_is_slash, clk, arst_n, m_tvalid && !m_tlast,
		m_tdata == CH_SLASH)

	// The byte that follows a released slash comes right after it.
	`CCS_ASSERT_NEXT(a_pair_completes, clk, arst_n, m_tvalid && m_tready && !m_tlast,
		m_tvalid && m_tlast)

endmodule

`default_nettype wire

// ===== rtl/ccs_front.sv =====
// ---------------------------------------------------------------------------
// ccs_front
// Accepts text bytes, tracks the comment scanning mode and issues commands.
// ---------------------------------------------------------------------------
`default_nettype none

module ccs_front
	import ccs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	input  wire logic       queue_full,
	output logic            in_ready,
	output logic            push,
	output cmd_t            push_cmd
);

	mode_t mode_q;
	mode_t mode_next;
	logic  emit;
	logic  accept;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		mode_next     = mode_q;
		emit          = 1'b0;
		push_cmd.pair = 1'b0;
		push_cmd.data = in_byte;
		unique case (mode_q)
			MODE_SLASH: begin
				if (in_byte == CH_SLASH) begin
					mode_next = MODE_LINE;
				end else if (in_byte == CH_STAR) begin
					mode_next = MODE_BLOCK;
				end else begin
					emit          = 1'b1;
					push_cmd.pair = 1'b1;
					mode_next     = MODE_NORMAL;
				end
			end
			MODE_LINE: begin
				if (in_byte == CH_NL) begin
					mode_next = MODE_NORMAL;
				end
			end
			MODE_BLOCK: begin
				if (in_byte == CH_STAR) begin
					mode_next = MODE_STAR;
				end
			end
			MODE_STAR: begin
				if (in_byte == CH_SLASH) begin
					mode_next = MODE_NORMAL;
				end else if (in_byte != CH_STAR) begin
					mode_next = MODE_BLOCK;
				end
			end
			default: begin
				// Normal text; a slash on the last byte has nothing to wait for.
				if (in_byte == CH_SLASH && !in_last) begin
					mode_next = MODE_SLASH;
				end else begin
					emit      = 1'b1;
					mode_next = MODE_NORMAL;
				end
			end
		endcase
		if (in_last) begin
			mode_next = MODE_NORMAL;
		end
	end

	assign push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
		end else if (accept) begin
			mode_q <= mode_next;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ccs_queue.sv =====
// ---------------------------------------------------------------------------
// ccs_queue
// Short command queue between the scanner and the output stage.
// ---------------------------------------------------------------------------
`default_nettype none

module ccs_queue
	import ccs_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	input  wire logic pop,
	output logic      full,
	output logic      not_empty,
	output cmd_t      head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	cmd_t          store_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign head      = store_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ccs_back.sv =====
// ---------------------------------------------------------------------------
// ccs_back
// Expands queued commands into output transactions, one byte per beat.
// ---------------------------------------------------------------------------
`default_nettype none

module ccs_back
	import ccs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cmd_valid,
	input  wire cmd_t       cmd,
	output logic            pop,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            out_last
);

	// Set once the held slash of a pair command has gone out.
	logic slash_done_q;
	logic first_of_pair;
	logic beat;

	assign first_of_pair = cmd.pair && !slash_done_q;
	assign out_valid     = cmd_valid;
	assign out_byte      = first_of_pair ? CH_SLASH : cmd.data;
	assign out_last      = !first_of_pair;
	assign beat          = out_valid && out_ready;
	assign pop           = beat && !first_of_pair;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slash_done_q <= 1'b0;
		end else if (beat) begin
			slash_done_q <= first_of_pair;
		end
	end

endmodule

`default_nettype wire

// ===== test/ccs_checker.sv =====
// ---------------------------------------------------------------------------
// ccs_checker
// Watches both stream channels of the comment stripper. It predicts the kept
// bytes of every accepted input transaction and compares each accepted output
// transaction with the oldest prediction.
// ---------------------------------------------------------------------------
module ccs_checker
	import ccs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	input  wire logic       s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] text_byte
	input  wire logic       s_tlast,   // end_of_text
	input  wire logic       m_tvalid,
	input  wire logic       m_tready,
	input  wire logic [7:0] m_tdata,   // [7:0] kept_byte
	input  wire logic       m_tlast,   // run_last
	output int              fail_count,
	output int              expected_left
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] kept;
		logic       last;
	} kept_item_t;

	kept_item_t kept_q[$];
	mode_t      scan_state = MODE_NORMAL;
	int         mismatches = 0;
	int         pending = 0;

	assign fail_count    = mismatches;
	assign expected_left = pending;

	// Advances the scanner by one text byte and queues the bytes it keeps.
	task automatic predict_kept(input logic [7:0] text_byte, input logic end_of_text);
		logic [7:0] kept[2];
		int         n;
		mode_t      next_state;
		n = 0;
		next_state = scan_state;
		case (scan_state)
			MODE_SLASH: begin
				if (text_byte == CH_SLASH) begin
					next_state = MODE_LINE;
				end else if (text_byte == CH_STAR) begin
					next_state = MODE_BLOCK;
				end else begin
					kept[0] = CH_SLASH;
					kept[1] = text_byte;
					n = 2;
					next_state = MODE_NORMAL;
				end
			end
			MODE_LINE: begin
				if (text_byte == CH_NL)
					next_state = MODE_NORMAL;
			end
			MODE_BLOCK: begin
				if (text_byte == CH_STAR)
					next_state = MODE_STAR;
			end
			MODE_STAR: begin
				if (text_byte == CH_SLASH)
					next_state = MODE_NORMAL;
				else if (text_byte != CH_STAR)
					next_state = MODE_BLOCK;
			end
			default: begin
				if (text_byte == CH_SLASH && !end_of_text) begin
					next_state = MODE_SLASH;
				end else begin
					kept[0] = text_byte;
					n = 1;
					next_state = MODE_NORMAL;
				end
			end
		endcase
		// Whatever is open at the end of a text is closed with it.
		if (end_of_text)
			next_state = MODE_NORMAL;
		scan_state = next_state;
		for (int i = 0; i < n; i++)
			kept_q.insert(kept_q.size(), '{kept: kept[i], last: (i == n - 1)});
	endtask

	always @(posedge clk or negedge arst_n) begin
		kept_item_t exp_item;
		if (!arst_n) begin
			kept_q.delete();
			scan_state = MODE_NORMAL;
		end else begin
			// Outputs first: a byte accepted in this cycle cannot have caused one yet.
			if (m_tvalid && m_tready) begin
				if (kept_q.size() == 0) begin
					$error("unexpected output transaction: kept_byte %h run_last %b",
						m_tdata, m_tlast);
					mismatches++;
				end else begin
					exp_item = kept_q.pop_front();
					if (m_tdata !== exp_item.kept) begin
						$error("kept_byte: expected %h, got %h", exp_item.kept, m_tdata);
						mismatches++;
					end
					if (m_tlast !== exp_item.last) begin
						$error("run_last: expected %b, got %b", exp_item.last, m_tlast);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready)
				predict_kept(s_tdata, s_tlast);
		end
		pending = kept_q.size();
	end

endmodule

// ===== test/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Testbench of the C comment stripper. A directed run covers every scanner
// transition but star back to block, and the end-of-text cases, then random text rich in slashes,
// stars and newlines runs under several idle and stall mixes, including one
// long receiver hold-off. Checking is done by ccs_checker.
// ---------------------------------------------------------------------------
module tb;
	import ccs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES      = 200;
	localparam int RANDOM_PER_PHASE = 310;
	localparam int DRAIN_LIMIT      = 5000;
	localparam int SRC_IDLE [4]     = '{0, 48, 0, 13};
	localparam int SINK_STALL [4]   = '{0, 0, 48, 13};

	// Each entry is {end_of_text, text_byte}.
	localparam logic [8:0] DIRECTED [25] = '{
		{1'b0, 8'h61}, {1'b0, 8'h00}, {1'b0, 8'hFF},
		{1'b0, CH_SLASH}, {1'b0, 8'h78},
		{1'b0, CH_SLASH}, {1'b0, CH_SLASH}, {1'b0, 8'h63}, {1'b0, CH_NL},
		{1'b0, CH_SLASH}, {1'b0, CH_STAR}, {1'b0, CH_SLASH},
		{1'b0, CH_STAR}, {1'b0, CH_STAR}, {1'b0, CH_SLASH},
		{1'b1, CH_SLASH},
		{1'b0, CH_SLASH}, {1'b1, CH_STAR},
		{1'b0, CH_SLASH}, {1'b1, CH_SLASH},
		{1'b0, CH_SLASH}, {1'b0, CH_STAR}, {1'b1, 8'h71},
		{1'b0, CH_STAR}, {1'b1, CH_NL}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;

	int   fail_count;
	int   expected_left;
	int   src_idle = 0;
	int   sink_stall = 0;
	logic hold_on = 1'b0;
	logic hold_done = 1'b0;
	int   hold_count = 0;

	always #5ns clk = ~clk;

	c_comment_stripper_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	ccs_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tlast       (s_tlast),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.fail_count    (fail_count),
		.expected_left (expected_left)
	);

	// Receiver: random stalls, plus one long hold-off so the queue fills up.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_on && !hold_done) begin
			m_tready <= 1'b0;
			hold_count++;
			if (hold_count == HOLD_CYCLES)
				hold_done <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_stall);
		end
	end

	// Mostly comment syntax so that every scanner mode is visited often.
	function automatic logic [7:0] pick_text_byte();
		int r;
		r = $urandom_range(99);
		if (r < 25)
			return CH_SLASH;
		else if (r < 45)
			return CH_STAR;
		else if (r < 55)
			return CH_NL;
		else if (r < 65)
			return 8'($urandom_range(255));
		else
			return 8'($urandom_range(8'h7A, 8'h61));
	endfunction

	task automatic send_text_byte(input logic [7:0] text_byte, input logic end_of_text);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= text_byte;
		s_tlast  <= end_of_text;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	initial begin
		int wait_cycles;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			send_text_byte(DIRECTED[i][7:0], DIRECTED[i][8]);

		for (int phase = 0; phase < 4; phase++) begin
			src_idle = SRC_IDLE[phase];
			sink_stall <= SINK_STALL[phase];
			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				if (phase == 0 && i == 20)
					hold_on <= 1'b1;
				send_text_byte(pick_text_byte(), $urandom_range(39) == 0);
			end
		end
		s_tvalid <= 1'b0;

		for (wait_cycles = 0; expected_left != 0 && wait_cycles < DRAIN_LIMIT; wait_cycles++)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (expected_left != 0)
			$error("%0d expected kept bytes never arrived", expected_left);

		if (fail_count == 0 && expected_left == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule
